### rtl/fsr_pkg.sv
// Shared types and constants for the framed serial receiver.
package fsr_pkg;

  localparam int unsigned MAX_FRAME_DEF = 255;

  localparam logic [7:0] MARKER_RESET = 8'h55;
  localparam logic [7:0] LEN_MIN      = 8'd3;

  localparam logic [7:0] TYPE_STATUS = 8'd1;
  localparam logic [7:0] TYPE_MOTOR  = 8'd2;
  localparam logic [7:0] TYPE_LIGHT  = 8'd3;
  localparam logic [7:0] TYPE_ERROR  = 8'd4;

  localparam logic [2:0] KIND_STATUS  = 3'd0;
  localparam logic [2:0] KIND_MOTOR   = 3'd1;
  localparam logic [2:0] KIND_LIGHT   = 3'd2;
  localparam logic [2:0] KIND_ERROR   = 3'd3;
  localparam logic [2:0] KIND_UNKNOWN = 3'd4;

  localparam logic [7:0] BIT_BUTTON = 8'h01;
  localparam logic [7:0] BIT_OPEN   = 8'h02;
  localparam logic [7:0] BIT_CLOSED = 8'h04;
  localparam logic [7:0] BIT_FAULT  = 8'h08;

  typedef struct packed {
    logic [31:0] fault_time;
    logic [31:0] closed_time;
    logic [31:0] opened_time;
    logic [31:0] button_time;
    logic [7:0]  status_bits;
    logic [7:0]  frame_length;
    logic [7:0]  first_data;
    logic [2:0]  message_kind;
    logic        frame_good;
  } result_t;

endpackage

### rtl/fsr_parser.sv
// Input register, frame tracking, checksum and status store of the receiver.
module fsr_parser #(
  parameter int unsigned MAX_FRAME = fsr_pkg::MAX_FRAME_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic [31:0]      in_time,
  input  logic [7:0]       start_marker,
  input  logic             res_room,
  output logic             res_valid,
  output fsr_pkg::result_t res
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic [31:0] s1_time_r;
  logic        s1_fire;

  logic        in_frame_r, in_frame_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  expected_length_r, expected_length_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic [7:0]  frame_type_r, frame_type_nxt;
  logic [7:0]  data_byte_r, data_byte_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [31:0] button_time_r, button_time_nxt;
  logic [31:0] opened_time_r, opened_time_nxt;
  logic [31:0] closed_time_r, closed_time_nxt;
  logic [31:0] fault_time_r, fault_time_nxt;

  logic [7:0]  cnt;
  logic        has_data;
  logic        good;
  logic [7:0]  first;
  logic [2:0]  kind;

  assign s1_fire      = s1_valid_r && res_room;
  assign in_ready     = !s1_valid_r || s1_fire;
  assign s1_valid_nxt = (in_valid && in_ready) || (s1_valid_r && !s1_fire);

  always_comb begin
    case (frame_type_r)
      fsr_pkg::TYPE_STATUS: kind = fsr_pkg::KIND_STATUS;
      fsr_pkg::TYPE_MOTOR:  kind = fsr_pkg::KIND_MOTOR;
      fsr_pkg::TYPE_LIGHT:  kind = fsr_pkg::KIND_LIGHT;
      fsr_pkg::TYPE_ERROR:  kind = fsr_pkg::KIND_ERROR;
      default:              kind = fsr_pkg::KIND_UNKNOWN;
    endcase
  end

  always_comb begin
    cnt      = byte_count_r + 8'd1;
    has_data = expected_length_r > fsr_pkg::LEN_MIN;
    first    = has_data ? data_byte_r : 8'd0;
    good     = (running_sum_r == s1_byte_r) &&
               !((frame_type_r == fsr_pkg::TYPE_STATUS) && !has_data);

    in_frame_nxt        = in_frame_r;
    byte_count_nxt      = byte_count_r;
    expected_length_nxt = expected_length_r;
    running_sum_nxt     = running_sum_r;
    frame_type_nxt      = frame_type_r;
    data_byte_nxt       = data_byte_r;
    status_nxt          = status_r;
    button_time_nxt     = button_time_r;
    opened_time_nxt     = opened_time_r;
    closed_time_nxt     = closed_time_r;
    fault_time_nxt      = fault_time_r;

    res_valid        = 1'b0;
    res.frame_good   = 1'b0;
    res.message_kind = kind;
    res.first_data   = first;
    res.frame_length = expected_length_r;

    if (s1_fire) begin
      if (!in_frame_r) begin
        if (s1_byte_r == start_marker) begin
          in_frame_nxt        = 1'b1;
          byte_count_nxt      = 8'd0;
          expected_length_nxt = 8'd0;
          running_sum_nxt     = 8'd0;
          frame_type_nxt      = 8'd0;
          data_byte_nxt       = 8'd0;
        end
      end else if (cnt == 8'd1) begin
        if (s1_byte_r < fsr_pkg::LEN_MIN ||
            {1'b0, s1_byte_r} > 9'(MAX_FRAME > 255 ? 255 : MAX_FRAME)) begin
          // Bad length: report and go back to hunting.
          res_valid        = 1'b1;
          res.message_kind = fsr_pkg::KIND_UNKNOWN;
          res.first_data   = 8'd0;
          res.frame_length = s1_byte_r;
          in_frame_nxt        = 1'b0;
          byte_count_nxt      = 8'd0;
          expected_length_nxt = 8'd0;
          running_sum_nxt     = 8'd0;
          frame_type_nxt      = 8'd0;
          data_byte_nxt       = 8'd0;
        end else begin
          byte_count_nxt      = cnt;
          expected_length_nxt = s1_byte_r;
        end
      end else if (cnt == expected_length_r) begin
        // Checksum byte: close the frame, update the status store on a good status frame.
        res_valid      = 1'b1;
        res.frame_good = good;
        if (good && frame_type_r == fsr_pkg::TYPE_STATUS) begin
          status_nxt = first;
          if ((first & fsr_pkg::BIT_BUTTON) != 8'd0) button_time_nxt = s1_time_r;
          if ((first & fsr_pkg::BIT_OPEN)   != 8'd0) opened_time_nxt = s1_time_r;
          if ((first & fsr_pkg::BIT_CLOSED) != 8'd0) closed_time_nxt = s1_time_r;
          if ((first & fsr_pkg::BIT_FAULT)  != 8'd0) fault_time_nxt  = s1_time_r;
        end
        in_frame_nxt        = 1'b0;
        byte_count_nxt      = 8'd0;
        expected_length_nxt = 8'd0;
        running_sum_nxt     = 8'd0;
        frame_type_nxt      = 8'd0;
        data_byte_nxt       = 8'd0;
      end else begin
        byte_count_nxt  = cnt;
        running_sum_nxt = running_sum_r + s1_byte_r;
        if (cnt == 8'd2) frame_type_nxt = s1_byte_r;
        if (cnt == 8'd3) data_byte_nxt  = s1_byte_r;
      end
    end

    res.status_bits = status_nxt;
    res.button_time = button_time_nxt;
    res.opened_time = opened_time_nxt;
    res.closed_time = closed_time_nxt;
    res.fault_time  = fault_time_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r        <= 1'b0;
      in_frame_r        <= 1'b0;
      byte_count_r      <= 8'd0;
      expected_length_r <= 8'd0;
      running_sum_r     <= 8'd0;
      frame_type_r      <= 8'd0;
      data_byte_r       <= 8'd0;
      status_r          <= 8'd0;
      button_time_r     <= 32'd0;
      opened_time_r     <= 32'd0;
      closed_time_r     <= 32'd0;
      fault_time_r      <= 32'd0;
    end else begin
      s1_valid_r        <= s1_valid_nxt;
      in_frame_r        <= in_frame_nxt;
      byte_count_r      <= byte_count_nxt;
      expected_length_r <= expected_length_nxt;
      running_sum_r     <= running_sum_nxt;
      frame_type_r      <= frame_type_nxt;
      data_byte_r       <= data_byte_nxt;
      status_r          <= status_nxt;
      button_time_r     <= button_time_nxt;
      opened_time_r     <= opened_time_nxt;
      closed_time_r     <= closed_time_nxt;
      fault_time_r      <= fault_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
      s1_time_r <= in_time;
    end
  end

  a_hunt_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !in_frame_r) |-> !res_valid)
    else $error("result produced while hunting");

  a_hunt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (byte_count_r == 8'd0 && running_sum_r == 8'd0))
    else $error("frame counters not cleared while hunting");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (in_frame_r && byte_count_r != 8'd0) |-> (byte_count_r < expected_length_r))
    else $error("byte count ran past the frame length");

endmodule

### rtl/fsr_out_buf.sv
// Two-entry output register with skid entry for result items.
module fsr_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fsr_pkg::result_t push_data,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output fsr_pkg::result_t out_data
);

  logic [1:0]       count_r, count_nxt;
  fsr_pkg::result_t data0_r, data1_r;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count_r != 2'd0;
  assign room      = count_r != 2'd2;
  assign out_data  = data0_r;

  always_comb begin
    count_nxt = count_r;
    case (count_r)
      2'd0:    if (push) count_nxt = 2'd1;
      2'd1:    if (push && !pop) count_nxt = 2'd2;
               else if (pop && !push) count_nxt = 2'd0;
      2'd2:    if (pop) count_nxt = 2'd1;
      default: count_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (count_r)
      2'd0:    if (push) data0_r <= push_data;
      2'd1:    if (push && pop) data0_r <= push_data;
               else if (push) data1_r <= push_data;
      2'd2:    if (pop) data0_r <= data1_r;
      default: data0_r <= data0_r;
    endcase
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd2 && !pop) |=> count_r == 2'd2)
    else $error("output buffer lost its full state");

endmodule

### rtl/framed_serial_receiver.sv
// Top level of the framed serial receiver: input channel, config register, output channel.
//
// Usage:
//   The input channel carries one received serial byte and the millisecond time at
//   which it is handled. While hunting, bytes other than the start marker are dropped.
//   After the marker comes a length byte (counting itself, type, data and checksum),
//   the type, length-3 data bytes and an additive mod-256 checksum over type and data.
//   Every finished or rejected frame gives one result item on the output channel with
//   the good flag, message kind, first data byte, length, and the status byte and the
//   four event timestamps as they stand after the frame.
//   The start marker is written through cfg_wr_en/cfg_wr_data; write it only while idle.
// Timing:
//   One item per cycle is accepted while in_tready is high. A byte is held in the input
//   register; its result is then written into the output buffer, which raises out_tvalid.
// Reset:
//   rst_n (synchronous, active low) returns to hunting, sets the marker to 0x55, clears
//   the status byte and the timestamps and empties the output buffer.
// Stall:
//   A two-entry output buffer lets the receiver keep taking bytes while one result waits;
//   in_tready drops only when the buffer is full and a byte is waiting to be processed.
module framed_serial_receiver #(
  parameter int unsigned MAX_FRAME = fsr_pkg::MAX_FRAME_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: [7:0] rx_byte, [39:8] now_ms
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,
  // out_tdata: [7:0] first_data, [15:8] frame_length, [23:16] status_bits,
  //   [55:24] button_time, [87:56] opened_time, [119:88] closed_time,
  //   [151:120] fault_time
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [151:0] out_tdata,
  // out_tuser: [0] frame_good, [3:1] message_kind
  output logic [3:0]   out_tuser,
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data
);

  logic [7:0]       start_marker_r;
  logic             res_valid;
  logic             res_room;
  fsr_pkg::result_t res;
  fsr_pkg::result_t out_res;

  // Hold the start marker until software writes a new one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= fsr_pkg::MARKER_RESET;
    end else if (cfg_wr_en) begin
      start_marker_r <= cfg_wr_data;
    end
  end

  fsr_parser #(
    .MAX_FRAME(MAX_FRAME)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_byte      (in_tdata[7:0]),
    .in_time      (in_tdata[39:8]),
    .start_marker (start_marker_r),
    .res_room     (res_room),
    .res_valid    (res_valid),
    .res          (res)
  );

  fsr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .room      (res_room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  // Pack the result item onto the stream ports.
  assign out_tdata = {out_res.fault_time, out_res.closed_time, out_res.opened_time,
                      out_res.button_time, out_res.status_bits, out_res.frame_length,
                      out_res.first_data};
  assign out_tuser = {out_res.message_kind, out_res.frame_good};

endmodule

### dv/framed_serial_receiver_tb.sv
// Self-checking testbench for the framed serial receiver: framed byte traffic, marker changes.
module framed_serial_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DRAIN_CYCLES = 8;     // leave slack for the output path to drain
  localparam int unsigned WHOLE_FRAME  = 1024;  // keep count that never truncates a frame
  localparam int unsigned PHASE_BYTES  = 200;   // frame bytes per marker setting

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [39:0]  in_tdata = '0;     // [7:0] rx_byte, [39:8] now_ms
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [151:0] out_tdata;         // [7:0] first_data, [15:8] frame_length, [23:16] status_bits,
                                   // [55:24] button_time, [87:56] opened_time,
                                   // [119:88] closed_time, [151:120] fault_time
  logic [3:0]   out_tuser;         // [0] frame_good, [3:1] message_kind
  logic         cfg_wr_en = 1'b0;
  logic [7:0]   cfg_wr_data = '0;

  framed_serial_receiver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bytes waiting to be sent, {now_ms, rx_byte}, and frame results still to come out.
  logic [39:0]      rx_items_q[$];
  fsr_pkg::result_t pending_results[$];

  int unsigned mismatch_cnt = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  bit          quiet_phase = 1'b0;  // no idling on either side while set

  // Receiver state as the block should hold it.
  logic [7:0]  marker = fsr_pkg::MARKER_RESET;
  bit          framing = 1'b0;
  logic [7:0]  frame_pos = '0;
  logic [7:0]  frame_len = '0;
  logic [7:0]  frame_sum = '0;
  logic [7:0]  frame_type = '0;
  logic [7:0]  frame_first = '0;
  logic [7:0]  door_status = '0;
  logic [31:0] event_ms[4] = '{default: '0};

  function automatic void drop_frame();
    framing     = 1'b0;
    frame_pos   = '0;
    frame_len   = '0;
    frame_sum   = '0;
    frame_type  = '0;
    frame_first = '0;
  endfunction

  function automatic logic [2:0] kind_for_type(input logic [7:0] t);
    case (t)
      fsr_pkg::TYPE_STATUS: return fsr_pkg::KIND_STATUS;
      fsr_pkg::TYPE_MOTOR:  return fsr_pkg::KIND_MOTOR;
      fsr_pkg::TYPE_LIGHT:  return fsr_pkg::KIND_LIGHT;
      fsr_pkg::TYPE_ERROR:  return fsr_pkg::KIND_ERROR;
      default:              return fsr_pkg::KIND_UNKNOWN;
    endcase
  endfunction

  function automatic void post_result(input logic good, input logic [2:0] kind,
                                      input logic [7:0] first, input logic [7:0] len);
    fsr_pkg::result_t r;
    r.frame_good   = good;
    r.message_kind = kind;
    r.first_data   = first;
    r.frame_length = len;
    r.status_bits  = door_status;
    r.button_time  = event_ms[0];
    r.opened_time  = event_ms[1];
    r.closed_time  = event_ms[2];
    r.fault_time   = event_ms[3];
    pending_results.push_back(r);
  endfunction

  // Advance the receiver state by one accepted byte; queue the frame result it finishes.
  function automatic void track_byte(input logic [7:0] b, input logic [31:0] ms);
    logic       has_data;
    logic       good;
    logic [7:0] first;
    if (!framing) begin
      if (b == marker) begin
        drop_frame();
        framing = 1'b1;
      end
      return;
    end
    frame_pos = frame_pos + 8'd1;
    if (frame_pos == 8'd1) begin
      frame_len = b;
      if (b < fsr_pkg::LEN_MIN || int'(b) > int'(fsr_pkg::MAX_FRAME_DEF)) begin
        post_result(1'b0, fsr_pkg::KIND_UNKNOWN, 8'h00, b);
        drop_frame();
      end
      return;
    end
    if (frame_pos == frame_len) begin
      has_data = (frame_len > fsr_pkg::LEN_MIN);
      first    = has_data ? frame_first : 8'h00;
      good     = (frame_sum == b) && !(frame_type == fsr_pkg::TYPE_STATUS && !has_data);
      if (good && frame_type == fsr_pkg::TYPE_STATUS) begin
        if ((first & fsr_pkg::BIT_BUTTON) != 0) event_ms[0] = ms;
        if ((first & fsr_pkg::BIT_OPEN) != 0)   event_ms[1] = ms;
        if ((first & fsr_pkg::BIT_CLOSED) != 0) event_ms[2] = ms;
        if ((first & fsr_pkg::BIT_FAULT) != 0)  event_ms[3] = ms;
        door_status = first;
      end
      post_result(good, kind_for_type(frame_type), first, frame_len);
      drop_frame();
      return;
    end
    if (frame_pos == 8'd2) frame_type = b;
    else if (frame_pos == 8'd3) frame_first = b;
    frame_sum = frame_sum + b;
  endfunction

  // Mostly no gap, some short ones, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (quiet_phase || r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic void note_failure(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) note_failure($sformatf("%s: expected %h, got %h", name, want, got));
  endfunction

  function automatic void check_result();
    fsr_pkg::result_t want;
    if (pending_results.size() == 0) begin
      note_failure($sformatf("result with none expected: tuser %h tdata %h",
                             out_tuser, out_tdata));
      return;
    end
    want = pending_results.pop_front();
    check_field("frame_good",   32'(want.frame_good),   32'(out_tuser[0]));
    check_field("message_kind", 32'(want.message_kind), 32'(out_tuser[3:1]));
    check_field("first_data",   32'(want.first_data),   32'(out_tdata[7:0]));
    check_field("frame_length", 32'(want.frame_length), 32'(out_tdata[15:8]));
    check_field("status_bits",  32'(want.status_bits),  32'(out_tdata[23:16]));
    check_field("button_time",  want.button_time,       out_tdata[55:24]);
    check_field("opened_time",  want.opened_time,       out_tdata[87:56]);
    check_field("closed_time",  want.closed_time,       out_tdata[119:88]);
    check_field("fault_time",   want.fault_time,        out_tdata[151:120]);
  endfunction

  // Input side: predict on each accepted item, then present the next one after its gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) track_byte(in_tdata[7:0], in_tdata[39:8]);
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (rx_items_q.size() != 0) begin
          in_tdata  <= rx_items_q.pop_front();
          in_tvalid <= 1'b1;
          in_gap    <= pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: check each accepted result, stall at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (out_gap != 0) begin
        out_gap    <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_gap    <= pick_gap();
      end
    end
  end

  function automatic void push_byte(input logic [7:0] b, input logic [31:0] ms);
    rx_items_q.push_back({ms, b});
  endfunction

  // Queue marker, length, type, data and checksum; keep only the first 'keep' bytes.
  // Returns the number of bytes queued.
  function automatic int unsigned queue_frame(input logic [7:0] t, input logic [7:0] len,
                                              input logic [7:0] first, input bit sum_ok,
                                              input logic [31:0] last_ms,
                                              input int unsigned keep);
    logic [7:0]  body[$];
    logic [7:0]  sum;
    logic [7:0]  d;
    logic [7:0]  flip;
    int unsigned i;
    body.push_back(marker);
    body.push_back(len);
    if (len >= fsr_pkg::LEN_MIN) begin
      body.push_back(t);
      sum = t;
      for (i = 3; i < len; i++) begin
        d = (i == 3) ? first : 8'($urandom_range(255));
        body.push_back(d);
        sum = sum + d;
      end
      flip = 8'($urandom_range(255, 1));
      body.push_back(sum_ok ? sum : sum ^ flip);
    end
    while (body.size() > keep) void'(body.pop_back());
    for (i = 0; i < body.size(); i++)
      push_byte(body[i], (i == body.size() - 1) ? last_ms : $urandom);
    return body.size();
  endfunction

  // Let everything drain; close any open frame with filler bytes so the block ends hunting.
  task automatic settle();
    forever begin
      while (rx_items_q.size() != 0 || in_tvalid || pending_results.size() != 0)
        @(posedge clk);
      if (!framing) break;
      push_byte(8'($urandom_range(255)), $urandom);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_marker(input logic [7:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    marker = v;
  endtask

  // Directed frames against the reset marker: extremes, every kind and the corner cases.
  task automatic run_directed();
    // Ignore noise while hunting.
    push_byte(8'h00, 32'h0000_0000);
    push_byte(8'hFF, 32'hFFFF_FFFF);
    // Reject length bytes below the minimum.
    void'(queue_frame(fsr_pkg::TYPE_MOTOR, 8'd0, 8'h00, 1'b1, $urandom, WHOLE_FRAME));
    void'(queue_frame(fsr_pkg::TYPE_MOTOR, 8'd2, 8'h00, 1'b1, $urandom, WHOLE_FRAME));
    // Status frame without data: rejected even though the checksum matches.
    void'(queue_frame(fsr_pkg::TYPE_STATUS, 8'd3, 8'h00, 1'b1, $urandom, WHOLE_FRAME));
    // Good status frames stamping every time with all ones, then half of them with zero.
    void'(queue_frame(fsr_pkg::TYPE_STATUS, 8'd4, 8'h0F, 1'b1, 32'hFFFF_FFFF, WHOLE_FRAME));
    void'(queue_frame(fsr_pkg::TYPE_STATUS, 8'd4, 8'hFA, 1'b1, 32'h0000_0000, WHOLE_FRAME));
    // Marker value as frame content.
    void'(queue_frame(fsr_pkg::TYPE_MOTOR, 8'd5, fsr_pkg::MARKER_RESET, 1'b1, $urandom,
                      WHOLE_FRAME));
    // Bad checksums: status must stay untouched; then an error frame without data.
    void'(queue_frame(fsr_pkg::TYPE_LIGHT, 8'd4, 8'hFF, 1'b0, $urandom, WHOLE_FRAME));
    void'(queue_frame(fsr_pkg::TYPE_STATUS, 8'd4, 8'h03, 1'b0, $urandom, WHOLE_FRAME));
    void'(queue_frame(fsr_pkg::TYPE_ERROR, 8'd3, 8'h00, 1'b1, $urandom, WHOLE_FRAME));
    // Unknown types at both ends of the byte range.
    void'(queue_frame(8'h00, 8'd4, 8'h00, 1'b1, $urandom, WHOLE_FRAME));
    void'(queue_frame(8'hFF, 8'd4, 8'h80, 1'b1, $urandom, WHOLE_FRAME));
  endtask

  // Mostly well-formed frames with random content, some noise, bad lengths and cut frames.
  task automatic run_random(input int unsigned quota);
    int unsigned sent;
    int unsigned r;
    int unsigned full;
    int unsigned keep;
    logic [7:0]  t;
    logic [7:0]  len;
    logic [7:0]  first;
    sent = 0;
    while (sent < quota) begin
      r = $urandom_range(99);
      if (r < 8) begin
        repeat ($urandom_range(4, 1)) push_byte(8'($urandom_range(255)), $urandom);
        continue;
      end
      r = $urandom_range(99);
      if (r < 40)      t = fsr_pkg::TYPE_STATUS;
      else if (r < 55) t = fsr_pkg::TYPE_MOTOR;
      else if (r < 70) t = fsr_pkg::TYPE_LIGHT;
      else if (r < 82) t = fsr_pkg::TYPE_ERROR;
      else             t = 8'($urandom_range(255));
      r = $urandom_range(99);
      if (r < 4)       len = 8'($urandom_range(2));
      else if (r < 70) len = 8'($urandom_range(8, 3));
      else if (r < 96) len = 8'($urandom_range(40, 9));
      else             len = 8'($urandom_range(255, 41));
      first = ($urandom_range(1) == 0) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
      full  = (len >= fsr_pkg::LEN_MIN) ? int'(len) + 1 : 2;
      keep  = ($urandom_range(99) < 5) ? $urandom_range(full - 1, 1) : full;
      sent += queue_frame(t, len, first, $urandom_range(99) < 85, $urandom, keep);
    end
  endtask

  initial begin
    logic [7:0] m;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    settle();
    // Walk the marker through both extremes, random values and back to its reset value.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       m = 8'h00;
        1:       m = 8'hFF;
        4:       m = fsr_pkg::MARKER_RESET;
        default: m = 8'($urandom_range(255));
      endcase
      write_marker(m);
      quiet_phase = (p == 2);
      @(negedge clk);
      run_random(PHASE_BYTES);
      settle();
    end
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### filelist.f
rtl/fsr_pkg.sv
rtl/fsr_parser.sv
rtl/fsr_out_buf.sv
rtl/framed_serial_receiver.sv
dv/framed_serial_receiver_tb.sv
